// ===== design/bdldp_pkg.sv =====
// Shared types and constants for the button qualifier with long and double press.
// No dependencies; used by button_debounce_long_double_press.
`default_nettype none

package bdldp_pkg;

  localparam int unsigned CNT_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned BTN_W     = 4;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned EV_MAX    = 3;
  localparam int unsigned EV_IDX_W  = 2;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W     = 2;
  localparam int unsigned FCNT_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_TICKS       = 3'd0,
    REG_PRESS_TICKS      = 3'd1,
    REG_RELEASE_TICKS    = 3'd2,
    REG_LONG_PRESS_TIME  = 3'd3,
    REG_DOUBLE_PRESS_MS  = 3'd4,
    REG_LONG_ENABLE_MASK = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_NEXT    = 2'd2
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t           kind;
    logic [BTN_W-1:0]   button;
    logic [MASK_W-1:0]  held;
    logic               last;
  } ev_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : CNT_W'(v + 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== design/button_debounce_long_double_press.sv =====
// Button qualifier: per-button debounce, long press to virtual button, double press.
// Depends on bdldp_pkg (types, event codes, saturating increment).
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  s_*     | in        | s_tvalid / s_tready       | s_tdata: one button sample
//  m_*     | out       | m_tvalid / m_tready       | m_tdata, m_tuser, m_tlast: events
//  cfg_*   | in        | cfg_we (no wait)          | cfg_index, cfg_data
//
// Flow: a sample is held in the input register, then is evaluated in a
// single pass that updates the button's entry and queues zero to three event words.
// The words are written into the event queue, which drives m_*. Samples stream at one
// per cycle while each yields at most one word and m_tready is high; the event
// queue (four words, one drained per cycle) sets the rate otherwise, and s_tready
// drops while a sample waits in the input register with two or more words queued.
// Reset clears all button entries at once.
`default_nettype none

module button_debounce_long_double_press #(
  parameter int unsigned BUTTON_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata from bit 0: button[3:0], long_target[3:0], long_valid, pressed,
  // now_ms[31:0], zero fill
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,
  // m_tdata from bit 0: event_button[3:0], held_mask[15:0], zero fill
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,
  // m_tuser from bit 0: event_kind[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  typedef enum logic [1:0] {
    PH_NOT_PRESSED = 2'd0,
    PH_SHORT       = 2'd1,
    PH_LONG        = 2'd2,
    PH_IDLE        = 2'd3
  } phase_t;

  // Configuration registers
  logic [15:0] idle_ticks;
  logic [15:0] press_ticks;
  logic [15:0] release_ticks;
  logic [15:0] long_press_time;
  logic [15:0] double_press_ms;
  logic [15:0] long_enable_mask;

  // Per-button state and globals
  phase_t                        phase         [BUTTON_COUNT];
  logic [bdldp_pkg::CNT_W-1:0]   press_count   [BUTTON_COUNT];
  logic [bdldp_pkg::CNT_W-1:0]   release_count [BUTTON_COUNT];
  logic [bdldp_pkg::CNT_W-1:0]   idle_count    [BUTTON_COUNT];
  logic [bdldp_pkg::MASK_W-1:0]  held_bits;
  logic [bdldp_pkg::TIME_W-1:0]  last_press_time;

  // Input register
  logic                          r_valid;
  logic [bdldp_pkg::BTN_W-1:0]   r_button;
  logic [bdldp_pkg::BTN_W-1:0]   r_long_target;
  logic                          r_long_valid;
  logic                          r_pressed;
  logic [bdldp_pkg::TIME_W-1:0]  r_now;

  // Event queue
  bdldp_pkg::ev_t                fifo [bdldp_pkg::FIFO_DEPTH];
  logic [bdldp_pkg::PTR_W-1:0]   wr_ptr;
  logic [bdldp_pkg::PTR_W-1:0]   rd_ptr;
  logic [bdldp_pkg::FCNT_W-1:0]  count;

  logic                          go;
  logic                          fire;
  logic                          pop;
  logic                          b_ok;
  logic                          has_long;
  logic [IDX_W-1:0]              bi;
  phase_t                        ph;
  logic [bdldp_pkg::CNT_W-1:0]   pc;
  logic [bdldp_pkg::CNT_W-1:0]   rc;
  logic [bdldp_pkg::CNT_W-1:0]   ic;
  logic [15:0]                   tt4;
  logic                          lp_on;
  logic                          dp_on;
  logic [bdldp_pkg::CNT_W-1:0]   pc_inc;
  logic [bdldp_pkg::CNT_W-1:0]   rc_inc;
  logic [bdldp_pkg::CNT_W-1:0]   ic_inc;
  logic                          press_hit;
  logic                          long_hit;
  logic                          release_hit;
  logic [bdldp_pkg::TIME_W-1:0]  since_press;
  logic                          dbl1;
  logic                          dbl2;
  logic [bdldp_pkg::MASK_W-1:0]  bit_b;
  logic [bdldp_pkg::MASK_W-1:0]  bit_lt;

  phase_t                        ph_next;
  logic [bdldp_pkg::CNT_W-1:0]   pc_next;
  logic [bdldp_pkg::CNT_W-1:0]   rc_next;
  logic [bdldp_pkg::CNT_W-1:0]   ic_next;
  logic [bdldp_pkg::MASK_W-1:0]  held_next;
  logic [bdldp_pkg::TIME_W-1:0]  lpt_next;
  logic [bdldp_pkg::EV_IDX_W-1:0] n_ev;
  bdldp_pkg::ev_t                evs [bdldp_pkg::EV_MAX];

  // Handshakes: evaluate only with room for a full burst of three words
  assign go       = (count <= bdldp_pkg::FCNT_W'(1));
  assign fire     = r_valid && go;
  assign s_tready = !r_valid || go;
  assign pop      = m_tvalid && m_tready;

  // Read the sampled button's entry
  assign b_ok     = ({1'b0, r_button} < 5'(BUTTON_COUNT));
  assign has_long = r_long_valid && ({1'b0, r_long_target} < 5'(BUTTON_COUNT));
  assign bi       = r_button[IDX_W-1:0];
  assign ph       = phase[bi];
  assign pc       = press_count[bi];
  assign rc       = release_count[bi];
  assign ic       = idle_count[bi];

  assign tt4   = {2'b00, long_press_time[15:2]};
  assign lp_on = (long_press_time != 16'd0);
  assign dp_on = (double_press_ms != 16'd0);

  // Press counter stops once past the long threshold when long press is on
  assign pc_inc = ((pc <= tt4) || !lp_on) ? bdldp_pkg::sat_inc(pc) : pc;
  assign rc_inc = (rc <= release_ticks) ? bdldp_pkg::sat_inc(rc) : rc;
  assign ic_inc = bdldp_pkg::sat_inc(ic);

  assign press_hit   = (pc_inc == press_ticks);
  assign long_hit    = (pc_inc == tt4) && lp_on && has_long &&
                       long_enable_mask[r_long_target];
  assign release_hit = (rc_inc == release_ticks);

  // Double press window; a real press just before in this sample restarts it at now
  assign since_press = r_now - last_press_time;
  assign dbl1 = dp_on && (since_press < {16'd0, double_press_ms});
  assign dbl2 = (press_hit && !dbl1) ? dp_on : dbl1;

  assign bit_b  = bdldp_pkg::MASK_W'(1) << r_button;
  assign bit_lt = bdldp_pkg::MASK_W'(1) << r_long_target;

  // Single-pass evaluation of one sample
  always_comb begin
    ph_next   = ph;
    pc_next   = pc;
    rc_next   = rc;
    ic_next   = ic;
    held_next = held_bits;
    lpt_next  = last_press_time;
    n_ev      = '0;
    for (int i = 0; i < bdldp_pkg::EV_MAX; i++) begin
      evs[i] = '0;
    end

    if (ph == PH_IDLE) begin
      // Lockout: count idle samples, then rearm
      if (ic_inc >= idle_ticks) begin
        ic_next = '0;
        pc_next = '0;
        rc_next = '0;
        ph_next = PH_NOT_PRESSED;
      end else begin
        ic_next = ic_inc;
      end
    end else if (r_pressed) begin
      rc_next = '0;
      pc_next = pc_inc;
      if (press_hit) begin
        ph_next = PH_SHORT;
        if (!dbl1) begin
          held_next = held_next | bit_b;
          lpt_next  = r_now;
        end
        evs[n_ev].kind   = dbl1 ? bdldp_pkg::EV_NEXT : bdldp_pkg::EV_PRESS;
        evs[n_ev].button = r_button;
        evs[n_ev].held   = held_next;
        n_ev = n_ev + 1'b1;
      end
      if (long_hit) begin
        // Hand the hold over to the virtual button
        ph_next   = PH_LONG;
        held_next = held_next & ~bit_b;
        evs[n_ev].kind   = bdldp_pkg::EV_RELEASE;
        evs[n_ev].button = r_button;
        evs[n_ev].held   = held_next;
        n_ev = n_ev + 1'b1;
        if (!dbl2) begin
          held_next = held_next | bit_lt;
          lpt_next  = r_now;
        end
        evs[n_ev].kind   = dbl2 ? bdldp_pkg::EV_NEXT : bdldp_pkg::EV_PRESS;
        evs[n_ev].button = r_long_target;
        evs[n_ev].held   = held_next;
        n_ev = n_ev + 1'b1;
      end
    end else begin
      pc_next = '0;
      rc_next = rc_inc;
      if (release_hit) begin
        if (ph == PH_SHORT) begin
          held_next = held_next & ~bit_b;
          evs[n_ev].kind   = bdldp_pkg::EV_RELEASE;
          evs[n_ev].button = r_button;
          evs[n_ev].held   = held_next;
          n_ev    = n_ev + 1'b1;
          ph_next = PH_IDLE;
        end else if (ph == PH_LONG) begin
          // Release of a long press names this sample's target, if it has one
          if (has_long) begin
            held_next = held_next & ~bit_lt;
            evs[n_ev].kind   = bdldp_pkg::EV_RELEASE;
            evs[n_ev].button = r_long_target;
            evs[n_ev].held   = held_next;
            n_ev = n_ev + 1'b1;
          end
          ph_next = PH_IDLE;
        end
      end
    end

    // Mark the final word of this sample
    for (int i = 0; i < bdldp_pkg::EV_MAX; i++) begin
      evs[i].last = (bdldp_pkg::EV_IDX_W'(i) == (n_ev - 1'b1));
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks       <= '0;
      press_ticks      <= '0;
      release_ticks    <= '0;
      long_press_time  <= '0;
      double_press_ms  <= '0;
      long_enable_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdldp_pkg::REG_IDLE_TICKS:       idle_ticks       <= cfg_data;
        bdldp_pkg::REG_PRESS_TICKS:      press_ticks      <= cfg_data;
        bdldp_pkg::REG_RELEASE_TICKS:    release_ticks    <= cfg_data;
        bdldp_pkg::REG_LONG_PRESS_TIME:  long_press_time  <= cfg_data;
        bdldp_pkg::REG_DOUBLE_PRESS_MS:  double_press_ms  <= cfg_data;
        bdldp_pkg::REG_LONG_ENABLE_MASK: long_enable_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      r_valid <= 1'b1;
    end else if (fire) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      r_button      <= s_tdata[3:0];
      r_long_target <= s_tdata[7:4];
      r_long_valid  <= s_tdata[8];
      r_pressed     <= s_tdata[9];
      r_now         <= s_tdata[41:10];
    end
  end

  // Button state machines and globals
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BUTTON_COUNT; k++) begin
        phase[k]         <= PH_NOT_PRESSED;
        press_count[k]   <= '0;
        release_count[k] <= '0;
        idle_count[k]    <= '0;
      end
      held_bits       <= '0;
      last_press_time <= '0;
    end else if (fire && b_ok) begin
      phase[bi]         <= ph_next;
      press_count[bi]   <= pc_next;
      release_count[bi] <= rc_next;
      idle_count[bi]    <= ic_next;
      held_bits         <= held_next;
      last_press_time   <= lpt_next;
    end
  end

  // Event queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (fire && b_ok) begin
        wr_ptr <= wr_ptr + bdldp_pkg::PTR_W'(n_ev);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ((fire && b_ok) ? bdldp_pkg::FCNT_W'(n_ev) : '0)
                     - bdldp_pkg::FCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && b_ok) begin
      for (int i = 0; i < bdldp_pkg::EV_MAX; i++) begin
        if (bdldp_pkg::EV_IDX_W'(i) < n_ev) begin
          fifo[wr_ptr + bdldp_pkg::PTR_W'(i)] <= evs[i];
        end
      end
    end
  end

  assign m_tvalid = (count != '0);
  assign m_tdata  = {4'b0000, fifo[rd_ptr].held, fifo[rd_ptr].button};
  assign m_tuser  = fifo[rd_ptr].kind;
  assign m_tlast  = fifo[rd_ptr].last;

  // Checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bdldp_pkg::FCNT_W'(bdldp_pkg::FIFO_DEPTH))
    else $error("event queue overflow");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && ph == PH_IDLE) |-> (n_ev == '0))
    else $error("event issued during lockout");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    (held_bits >> BUTTON_COUNT) == '0)
    else $error("held bit set for nonexistent button");

  a_hold_sample: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !fire) |=> (r_valid && $stable(r_button) && $stable(r_now)))
    else $error("pending sample lost");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |=> (count <= bdldp_pkg::FCNT_W'(bdldp_pkg::EV_MAX)))
    else $error("queue grew by more than one burst");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_long_double_press.
// Uses bdldp_pkg for register indexes, event kinds and the event word layout.
// Stimulus is a directed table followed by random press bursts.

module tb;

  localparam int BUTTONS     = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_GAP   = 12;   // cycles after the last word before a register write
  localparam int TAIL_GAP    = 20;   // cycles after the last word before the verdict
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off so the event queue fills

  // Per-button qualifier phases
  typedef enum logic [1:0] {
    PH_NOT_PRESSED = 2'd0,
    PH_SHORT       = 2'd1,
    PH_LONG        = 2'd2,
    PH_IDLE        = 2'd3
  } phase_t;

  typedef enum logic {
    ROW_SAMPLE = 1'b0,
    ROW_CFG    = 1'b1
  } row_kind_t;

  // One button sample, last field in the lowest bits as on s_tdata
  typedef struct packed {
    logic [31:0] now_ms;
    logic        pressed;
    logic        long_valid;
    logic [3:0]  long_target;
    logic [3:0]  button;
  } sample_t;

  typedef struct packed {
    row_kind_t             kind;
    bdldp_pkg::cfg_reg_t   reg_idx;
    logic [15:0]           reg_val;
    sample_t               smp;
    logic                  typed;     // expectation written into the row itself
    logic [1:0]            exp_n;     // zero or one event for typed rows
    bdldp_pkg::ev_kind_t   exp_kind;
    logic [3:0]            exp_btn;
    logic [15:0]           exp_held;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  button_debounce_long_double_press #(
    .BUTTON_COUNT(BUTTONS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the qualifier state and registers
  phase_t      phase_model   [BUTTONS];
  logic [15:0] press_cnt     [BUTTONS];
  logic [15:0] rel_cnt       [BUTTONS];
  logic [15:0] idle_cnt      [BUTTONS];
  logic [15:0] held_model;
  logic [31:0] last_press_model;
  logic [15:0] idle_ticks_cfg;
  logic [15:0] press_ticks_cfg;
  logic [15:0] release_ticks_cfg;
  logic [15:0] long_time_cfg;
  logic [15:0] double_ms_cfg;
  logic [15:0] long_mask_cfg;

  bdldp_pkg::ev_t  step_events[$];     // events of the sample being qualified
  bdldp_pkg::ev_t  pending_events[$];  // event words still owed by the block
  stim_row_t       directed_rows[$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          samples_sent = 0;
  int          tx_idle_pct = 20;
  int          rx_idle_pct = 61;
  bit          hold_req = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  // Free-running clock, 20 ns period
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: a correct run finishes far below the limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_events.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_model();
    for (int k = 0; k < BUTTONS; k++) begin
      phase_model[k] = PH_NOT_PRESSED;
      press_cnt[k]   = 16'd0;
      rel_cnt[k]     = 16'd0;
      idle_cnt[k]    = 16'd0;
    end
    held_model        = 16'd0;
    last_press_model  = 32'd0;
    idle_ticks_cfg    = 16'd0;
    press_ticks_cfg   = 16'd0;
    release_ticks_cfg = 16'd0;
    long_time_cfg     = 16'd0;
    double_ms_cfg     = 16'd0;
    long_mask_cfg     = 16'd0;
  endfunction

  // Counters stick at all-ones
  function automatic logic [15:0] bump_sat(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Stamp the event with the held mask as it stands after the event
  function automatic void add_event(input bdldp_pkg::ev_kind_t k, input logic [3:0] b);
    bdldp_pkg::ev_t e;
    e.kind   = k;
    e.button = b;
    e.held   = held_model;
    e.last   = 1'b0;
    step_events.push_back(e);
  endfunction

  // A press inside the double-press window turns into next-slot and leaves
  // the held mask and the press time stamp alone.
  function automatic void press_event(input logic [3:0] b, input logic [31:0] now);
    logic [31:0] since;
    since = now - last_press_model;
    if (double_ms_cfg != 16'd0 && since < {16'd0, double_ms_cfg}) begin
      add_event(bdldp_pkg::EV_NEXT, b);
    end else begin
      held_model       = held_model | (16'd1 << b);
      last_press_model = now;
      add_event(bdldp_pkg::EV_PRESS, b);
    end
  endfunction

  function automatic void release_event(input logic [3:0] b);
    held_model = held_model & ~(16'd1 << b);
    add_event(bdldp_pkg::EV_RELEASE, b);
  endfunction

  // Advance one button entry by one sample and collect the events it causes
  function automatic void qualify_sample(input sample_t s);
    logic [3:0]      b;
    logic [3:0]      lt;
    logic            has_long;
    logic [15:0]     long_cnt;
    bdldp_pkg::ev_t  tail;
    b        = s.button;
    lt       = s.long_target;
    has_long = s.long_valid && (lt < BUTTONS);
    long_cnt = long_time_cfg >> 2;
    step_events.delete();
    if (b >= BUTTONS) begin
      // ignored sample
    end else if (phase_model[b] == PH_IDLE) begin
      // lockout after release: count idle samples, then rearm, no events
      idle_cnt[b] = bump_sat(idle_cnt[b]);
      if (idle_cnt[b] >= idle_ticks_cfg) begin
        idle_cnt[b]    = 16'd0;
        press_cnt[b]   = 16'd0;
        rel_cnt[b]     = 16'd0;
        phase_model[b] = PH_NOT_PRESSED;
      end
    end else if (s.pressed) begin
      rel_cnt[b] = 16'd0;
      if (press_cnt[b] <= long_cnt || long_time_cfg == 16'd0)
        press_cnt[b] = bump_sat(press_cnt[b]);
      if (press_cnt[b] == press_ticks_cfg) begin
        press_event(b, s.now_ms);
        phase_model[b] = PH_SHORT;
      end
      // long hold: drop the real button, press the virtual one
      if (press_cnt[b] == long_cnt && long_time_cfg != 16'd0 && has_long &&
          long_mask_cfg[lt]) begin
        release_event(b);
        press_event(lt, s.now_ms);
        press_cnt[b]   = long_cnt;
        phase_model[b] = PH_LONG;
      end
    end else begin
      press_cnt[b] = 16'd0;
      if (rel_cnt[b] <= release_ticks_cfg)
        rel_cnt[b] = bump_sat(rel_cnt[b]);
      if (rel_cnt[b] == release_ticks_cfg) begin
        if (phase_model[b] == PH_SHORT) begin
          release_event(b);
          phase_model[b] = PH_IDLE;
        end else if (phase_model[b] == PH_LONG) begin
          // the release names this sample's target; without one it is silent
          if (has_long)
            release_event(lt);
          phase_model[b] = PH_IDLE;
        end
      end
    end
    if (step_events.size() > 0) begin
      tail      = step_events.pop_back();
      tail.last = 1'b1;
      step_events.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Idle pattern follows stimulus progress: sender idles lightly first, then
  // the receiver lightly, then a stretch with no idling at all.
  function automatic void pick_idle_mix();
    if (samples_sent < 130) begin
      tx_idle_pct = 20;
      rx_idle_pct = 61;
    end else if (samples_sent < 250) begin
      tx_idle_pct = 61;
      rx_idle_pct = 20;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endfunction

  // Called at a falling edge; returns at a falling edge with s_tvalid untouched
  // in that step, so the next word can keep valid high without a glitch.
  task automatic send_sample(input stim_row_t row);
    bdldp_pkg::ev_t typed_ev;
    pick_idle_mix();
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, row.smp};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    // word accepted at this edge
    samples_sent++;
    qualify_sample(row.smp);
    if (row.typed) begin
      if (row.exp_n != 2'd0) begin
        typed_ev.kind   = row.exp_kind;
        typed_ev.button = row.exp_btn;
        typed_ev.held   = row.exp_held;
        typed_ev.last   = 1'b1;
        pending_events.push_back(typed_ev);
      end
    end else begin
      foreach (step_events[k])
        pending_events.push_back(step_events[k]);
    end
    @(negedge clk);
  endtask

  // Hold the input side quiet until every owed word is out, then let any
  // sample that yields nothing clear the pipeline.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input bdldp_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bdldp_pkg::REG_IDLE_TICKS:       idle_ticks_cfg    = val;
      bdldp_pkg::REG_PRESS_TICKS:      press_ticks_cfg   = val;
      bdldp_pkg::REG_RELEASE_TICKS:    release_ticks_cfg = val;
      bdldp_pkg::REG_LONG_PRESS_TIME:  long_time_cfg     = val;
      bdldp_pkg::REG_DOUBLE_PRESS_MS:  double_ms_cfg     = val;
      bdldp_pkg::REG_LONG_ENABLE_MASK: long_mask_cfg     = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: random ready, with one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Output checker: each word against the oldest owed event
  always @(posedge clk) begin : event_check
    bdldp_pkg::ev_t got;
    bdldp_pkg::ev_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind   = bdldp_pkg::ev_kind_t'(m_tuser);
      got.button = m_tdata[3:0];
      got.held   = m_tdata[19:4];
      got.last   = m_tlast;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected word kind %0d button %0d held %h", got.kind,
                         got.button, got.held));
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.button !== want.button)
          report($sformatf("button %0d, want %0d", got.button, want.button));
        if (got.held !== want.held)
          report($sformatf("held %h, want %h", got.held, want.held));
        if (got.last !== want.last)
          report($sformatf("last %b, want %b", got.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  function automatic void row_cfg(input bdldp_pkg::cfg_reg_t idx, input logic [15:0] val);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    directed_rows.push_back(r);
  endfunction

  function automatic void row_smp(input logic [3:0] b, input logic [3:0] lt,
                                  input logic lv, input logic pr, input logic [31:0] now,
                                  input logic chk, input logic [1:0] n,
                                  input bdldp_pkg::ev_kind_t k,
                                  input logic [3:0] eb, input logic [15:0] eh);
    stim_row_t r;
    r                   = '0;
    r.kind              = ROW_SAMPLE;
    r.smp.button        = b;
    r.smp.long_target   = lt;
    r.smp.long_valid    = lv;
    r.smp.pressed       = pr;
    r.smp.now_ms        = now;
    r.typed             = chk;
    r.exp_n             = n;
    r.exp_kind          = k;
    r.exp_btn           = eb;
    r.exp_held          = eh;
    directed_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    // registers at reset: press and release thresholds of zero never fire
    row_smp(4'd0,  4'd0,  1'b0, 1'b1, 32'd0, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd15, 4'd15, 1'b1, 1'b0, 32'd1, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);

    // plain short press, release and a one-sample lockout
    row_cfg(bdldp_pkg::REG_PRESS_TICKS, 16'd2);
    row_cfg(bdldp_pkg::REG_RELEASE_TICKS, 16'd2);
    row_cfg(bdldp_pkg::REG_IDLE_TICKS, 16'd1);
    row_smp(4'd3, 4'd0, 1'b0, 1'b1, 32'd10, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd3, 4'd0, 1'b0, 1'b1, 32'd11, 1'b1, 2'd1, bdldp_pkg::EV_PRESS, 4'd3, 16'h0008);
    row_smp(4'd3, 4'd0, 1'b0, 1'b0, 32'd12, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd3, 4'd0, 1'b0, 1'b0, 32'd13, 1'b1, 2'd1, bdldp_pkg::EV_RELEASE, 4'd3,
            16'h0000);
    row_smp(4'd3, 4'd0, 1'b0, 1'b1, 32'd14, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);

    // long press to virtual button 5 (threshold 8 >> 2 = 2 samples)
    row_cfg(bdldp_pkg::REG_PRESS_TICKS, 16'd1);
    row_cfg(bdldp_pkg::REG_RELEASE_TICKS, 16'd1);
    row_cfg(bdldp_pkg::REG_IDLE_TICKS, 16'd0);
    row_cfg(bdldp_pkg::REG_LONG_PRESS_TIME, 16'd8);
    row_cfg(bdldp_pkg::REG_LONG_ENABLE_MASK, 16'h0020);
    row_smp(4'd1, 4'd5, 1'b1, 1'b1, 32'd100, 1'b1, 2'd1, bdldp_pkg::EV_PRESS, 4'd1, 16'h0002);
    row_smp(4'd1, 4'd5, 1'b1, 1'b1, 32'd101, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd1, 4'd5, 1'b1, 1'b0, 32'd102, 1'b1, 2'd1, bdldp_pkg::EV_RELEASE, 4'd5,
            16'h0000);
    row_smp(4'd1, 4'd5, 1'b1, 1'b0, 32'd103, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);

    // long release without a target: silent, virtual button stays held
    row_smp(4'd1, 4'd5, 1'b1, 1'b1, 32'd200, 1'b1, 2'd1, bdldp_pkg::EV_PRESS, 4'd1, 16'h0002);
    row_smp(4'd1, 4'd5, 1'b1, 1'b1, 32'd201, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd1, 4'd5, 1'b0, 1'b0, 32'd202, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd1, 4'd5, 1'b0, 1'b0, 32'd203, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);

    // target whose long action is not enabled: no long press
    row_smp(4'd2, 4'd6, 1'b1, 1'b1, 32'd300, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd2, 4'd6, 1'b1, 1'b1, 32'd301, 1'b1, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);

    // double press window: a close second press becomes next-slot
    row_cfg(bdldp_pkg::REG_DOUBLE_PRESS_MS, 16'd100);
    row_smp(4'd2, 4'd6, 1'b1, 1'b0, 32'd320, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd7, 4'd0, 1'b0, 1'b1, 32'd350, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);
    row_smp(4'd8, 4'd0, 1'b0, 1'b1, 32'd500, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0, 16'h0000);

    // register and time extremes
    row_cfg(bdldp_pkg::REG_DOUBLE_PRESS_MS, 16'hFFFF);
    row_cfg(bdldp_pkg::REG_LONG_PRESS_TIME, 16'hFFFF);
    row_cfg(bdldp_pkg::REG_LONG_ENABLE_MASK, 16'hFFFF);
    row_cfg(bdldp_pkg::REG_PRESS_TICKS, 16'hFFFF);
    row_cfg(bdldp_pkg::REG_RELEASE_TICKS, 16'hFFFF);
    row_cfg(bdldp_pkg::REG_IDLE_TICKS, 16'hFFFF);
    row_smp(4'd0,  4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0,
            16'h0);
    row_smp(4'd15, 4'd15, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0,
            16'h0);
    row_smp(4'd9,  4'd10, 1'b1, 1'b1, 32'hAAAA_5555, 1'b0, 2'd0, bdldp_pkg::EV_PRESS, 4'd0,
            16'h0);
  endfunction

  // ---------------------------------------------------------------------------
  // Random part
  // ---------------------------------------------------------------------------
  // Advance the millisecond clock; now and then jump anywhere so every bit moves
  function automatic logic [31:0] tick_ms();
    if ($urandom_range(0, 99) < 3)
      clock_ms = $urandom;
    else
      clock_ms = clock_ms + $urandom_range(0, 30);
    return clock_ms;
  endfunction

  // Each burst is one button held, released and left through its lockout;
  // a share of the words is noise on any button with any level.
  task automatic run_random_phase(input logic [15:0] idle_v, input logic [15:0] press_v,
                                  input logic [15:0] rel_v, input logic [15:0] long_v,
                                  input logic [15:0] dbl_v, input logic [15:0] mask_v,
                                  input int quota);
    stim_row_t   r;
    int          sent;
    int          n_press;
    int          n_rel;
    int          n_idle;
    logic [3:0]  b;
    logic [3:0]  lt;
    logic        lv;
    wait_idle();
    write_reg(bdldp_pkg::REG_IDLE_TICKS, idle_v);
    write_reg(bdldp_pkg::REG_PRESS_TICKS, press_v);
    write_reg(bdldp_pkg::REG_RELEASE_TICKS, rel_v);
    write_reg(bdldp_pkg::REG_LONG_PRESS_TIME, long_v);
    write_reg(bdldp_pkg::REG_DOUBLE_PRESS_MS, dbl_v);
    write_reg(bdldp_pkg::REG_LONG_ENABLE_MASK, mask_v);
    sent = 0;
    while (sent < quota) begin
      b       = 4'($urandom_range(0, 15));
      lt      = 4'($urandom_range(0, 15));
      lv      = ($urandom_range(0, 3) != 0);
      n_press = $urandom_range(1, 8);
      n_rel   = $urandom_range(1, 5);
      n_idle  = $urandom_range(0, 4);
      for (int k = 0; k < n_press + n_rel + n_idle && sent < quota; k++) begin
        r      = '0;
        r.kind = ROW_SAMPLE;
        // at release the target may vanish, which silences a long release
        if (k == n_press && $urandom_range(0, 3) == 0)
          lv = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) begin
          r.smp.button      = 4'($urandom_range(0, 15));
          r.smp.long_target = 4'($urandom_range(0, 15));
          r.smp.long_valid  = 1'($urandom_range(0, 1));
          r.smp.pressed     = 1'($urandom_range(0, 1));
        end else begin
          r.smp.button      = b;
          r.smp.long_target = lt;
          r.smp.long_valid  = lv;
          r.smp.pressed     = (k < n_press);
        end
        r.smp.now_ms = tick_ms();
        send_sample(r);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    clear_model();
    build_directed();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_sample(directed_rows[i]);
      end
    end

    run_random_phase(16'd2, 16'd3, 16'd2, 16'd12, 16'd0, 16'($urandom_range(0, 65535)), 60);
    // stall the output for a long stretch while samples keep coming
    hold_req = 1'b1;
    run_random_phase(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                     16'($urandom_range(0, 4)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 40)), 16'($urandom_range(0, 65535)), 60);
    run_random_phase(16'd0, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 40);
    run_random_phase(16'($urandom_range(0, 3)), 16'($urandom_range(1, 4)),
                     16'($urandom_range(1, 3)), 16'($urandom_range(4, 24)),
                     16'($urandom_range(1, 60)), 16'($urandom_range(0, 65535)), 70);
    run_random_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 20);
    run_random_phase(16'($urandom_range(0, 5)), 16'($urandom_range(1, 5)),
                     16'($urandom_range(0, 5)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 100)), 16'($urandom_range(0, 65535)), 100);

    wait_idle();
    repeat (TAIL_GAP) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== button_debounce_long_double_press.f =====
design/bdldp_pkg.sv
design/button_debounce_long_double_press.sv
sim/tb.sv
